FILE: sv/mrps_pkg.sv
// ----------------------------------------------------------------------------
// mrps_pkg
// Types and constants shared by the reference picture store.
// ----------------------------------------------------------------------------
package mrps_pkg;

  localparam int HANDLE_BITS = 8;
  localparam int ORDER_BITS  = 32;
  localparam int NUM_REFS    = 2;

  typedef logic [HANDLE_BITS-1:0]       handle_t;
  typedef logic signed [ORDER_BITS-1:0] order_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BUMP  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         pic_id;
    logic signed [31:0] order_count;
    logic               is_reference;
    logic               needs_output;
  } item_in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_id;
    logic       prev_valid;
    logic [7:0] prev_id;
    logic       next_valid;
    logic [7:0] next_id;
    logic       bump_pending;
  } item_out_t;

  typedef struct packed {
    logic    valid;
    logic    wants;
    handle_t handle;
    order_t  order;
  } ref_slot_t;

  typedef ref_slot_t [NUM_REFS-1:0] refs_t;

  typedef struct packed {
    logic    valid;
    logic    is_ref;
    logic    wants;
    handle_t handle;
    order_t  order;
  } pend_slot_t;

  typedef struct packed {
    refs_t      refs;
    pend_slot_t pend;
  } store_t;

  // handle as reported on the 8-bit result fields
  function automatic logic [7:0] handle_out(handle_t h);
    return 8'(h);
  endfunction

endpackage

FILE: sv/mpeg2_reference_picture_store.sv
// ----------------------------------------------------------------------------
// mpeg2_reference_picture_store
// Two reference slots plus one pending slot; add, bump, neighbour query, clear.
// ----------------------------------------------------------------------------
//  channel   | ports                    | handshake
//  ----------+--------------------------+-----------------------------------
//  command   | start_i, busy_o, item_i  | taken when start_i && !busy_o
//  result    | done_o, result_o         | one-cycle strobe, no back-pressure
//
//  One item per cycle; busy_o stays low. The item is registered on accept,
//  the store is updated and the result registered at the next edge.
//  Reset empties every slot. The result side cannot stall, so nothing ever
//  waits on it.
// ----------------------------------------------------------------------------
module mpeg2_reference_picture_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mrps_pkg::item_in_t  item_i,
  output logic                done_o,
  output mrps_pkg::item_out_t result_o
);
  import mrps_pkg::*;

  logic      valid_q;
  item_in_t  item_q;
  store_t    store_q, store_d;
  item_out_t res_d, res_q;
  logic      done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      item_q  <= '0;
    end else begin
      valid_q <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        item_q <= item_i;
      end
    end
  end

  mrps_step u_step (
    .store_i (store_q),
    .item_i  (item_q),
    .store_o (store_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= valid_q;
      if (valid_q) begin
        store_q <= store_d;
        res_q   <= res_d;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // every accepted item is followed by a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result strobe missing");

  // reported pending flag matches the stored pending slot
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.bump_pending == store_q.pend.valid))
    else $error("bump_pending out of step with store");

  // a clear leaves nothing pending
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && item_q.op == OP_CLEAR) |=> (!store_q.pend.valid &&
      !store_q.refs[0].valid && !store_q.refs[1].valid))
    else $error("clear left slots occupied");

  // handles read zero when their valid bit is low
  a_zero_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.out_valid || result_o.out_id == 8'd0) &&
                (result_o.prev_valid || result_o.prev_id == 8'd0) &&
                (result_o.next_valid || result_o.next_id == 8'd0)))
    else $error("handle set without valid");

endmodule

FILE: sv/mrps_step.sv
// ----------------------------------------------------------------------------
// mrps_step
// Next store contents and result for one operation (combinational).
// ----------------------------------------------------------------------------
module mrps_step (
  input  mrps_pkg::store_t    store_i,
  input  mrps_pkg::item_in_t  item_i,
  output mrps_pkg::store_t    store_o,
  output mrps_pkg::item_out_t res_o
);
  import mrps_pkg::*;

  // append to a free slot, else replace the lower-order one unless it is newer
  function automatic refs_t insert_ref(refs_t r, handle_t h, order_t o, logic w);
    refs_t t;
    logic  slot;
    t    = r;
    slot = 1'b0;
    if (!r[0].valid) begin
      t[0] = '{valid: 1'b1, wants: w, handle: h, order: o};
    end else if (!r[1].valid) begin
      t[1] = '{valid: 1'b1, wants: w, handle: h, order: o};
    end else begin
      slot = (r[0].order > r[1].order);
      if (!(r[slot].order > o)) begin
        t[slot] = '{valid: 1'b1, wants: w, handle: h, order: o};
      end
    end
    return t;
  endfunction

  handle_t id;
  order_t  oc;

  // bump selection
  logic    cand0, cand1, has_ref, rsel, pick_pend;
  order_t  best;

  // neighbour selection
  logic    above0, above1, pv0, pv1, nx0, nx1, prev_sel, next_sel;

  assign id = HANDLE_BITS'(item_i.pic_id);
  assign oc = ORDER_BITS'(item_i.order_count);

  assign cand0   = store_i.refs[0].valid && store_i.refs[0].wants;
  assign cand1   = store_i.refs[1].valid && store_i.refs[1].wants;
  assign has_ref = cand0 || cand1;
  // earlier slot wins ties
  assign rsel    = cand1 && (!cand0 || (store_i.refs[0].order > store_i.refs[1].order));
  assign best    = store_i.refs[rsel].order;
  assign pick_pend = store_i.pend.valid && store_i.pend.wants &&
                     (!has_ref || (best > store_i.pend.order));

  assign above0 = store_i.refs[0].order > oc;
  assign above1 = store_i.refs[1].order > oc;
  assign pv0    = store_i.refs[0].valid && !above0;
  assign pv1    = store_i.refs[1].valid && !above1;
  assign nx0    = store_i.refs[0].valid && above0;
  assign nx1    = store_i.refs[1].valid && above1;
  // prev: later slot wins ties; next: earlier slot wins ties
  assign prev_sel = pv1 && (!pv0 || !(store_i.refs[0].order > store_i.refs[1].order));
  assign next_sel = nx1 && (!nx0 || (store_i.refs[0].order > store_i.refs[1].order));

  always_comb begin
    store_o = store_i;
    res_o   = '0;
    case (item_i.op)
      OP_ADD: begin
        if (!item_i.is_reference || (store_i.refs[0].valid && store_i.refs[1].valid)) begin
          store_o.pend = '{valid: 1'b1, is_ref: item_i.is_reference,
                           wants: item_i.needs_output, handle: id, order: oc};
        end else begin
          store_o.refs = insert_ref(store_i.refs, id, oc, item_i.needs_output);
        end
      end
      OP_BUMP: begin
        if (pick_pend) begin
          res_o.out_valid     = 1'b1;
          res_o.out_id        = handle_out(store_i.pend.handle);
          store_o.pend.wants  = 1'b0;
        end else if (has_ref) begin
          res_o.out_valid              = 1'b1;
          res_o.out_id                 = handle_out(store_i.refs[rsel].handle);
          store_o.refs[rsel].wants     = 1'b0;
        end
        if (store_i.pend.valid && store_i.pend.is_ref) begin
          store_o.refs       = insert_ref(store_o.refs, store_i.pend.handle,
                                          store_i.pend.order, store_o.pend.wants);
          store_o.pend.valid = 1'b0;
        end else if (pick_pend) begin
          store_o.pend.valid = 1'b0;
        end
      end
      OP_QUERY: begin
        if (pv0 || pv1) begin
          res_o.prev_valid = 1'b1;
          res_o.prev_id    = handle_out(store_i.refs[prev_sel].handle);
        end
        if (nx0 || nx1) begin
          res_o.next_valid = 1'b1;
          res_o.next_id    = handle_out(store_i.refs[next_sel].handle);
        end
      end
      OP_CLEAR: begin
        store_o = '0;
      end
      default: begin
        store_o = store_i;
      end
    endcase
    res_o.bump_pending = store_o.pend.valid;
  end

endmodule

FILE: verif/mrps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrps_checker
// Watches the command and result channels of the reference picture store,
// predicts each result from its own copy of the slots and compares the
// results field by field, in order.
// ----------------------------------------------------------------------------
module mrps_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  mrps_pkg::item_in_t  item_i,
  input  logic                done_i,
  input  mrps_pkg::item_out_t result_i,
  output int unsigned         fail_count_o,
  output int unsigned         outstanding_o,
  output int unsigned         checked_o
);
  import mrps_pkg::*;

  localparam int PICK_NONE = -1;
  localparam int PICK_PEND = NUM_REFS;

  // predicted store contents
  logic    slot_valid  [NUM_REFS];
  logic    slot_wants  [NUM_REFS];
  handle_t slot_handle [NUM_REFS];
  order_t  slot_order  [NUM_REFS];
  logic    pend_valid, pend_is_ref, pend_wants;
  handle_t pend_handle;
  order_t  pend_order;

  item_out_t expected_results[$];

  task automatic empty_store();
    for (int i = 0; i < NUM_REFS; i++) begin
      slot_valid[i]  = 1'b0;
      slot_wants[i]  = 1'b0;
      slot_handle[i] = '0;
      slot_order[i]  = '0;
    end
    pend_valid  = 1'b0;
    pend_is_ref = 1'b0;
    pend_wants  = 1'b0;
    pend_handle = '0;
    pend_order  = '0;
  endtask

  task automatic store_slot(input int idx, input handle_t h, input order_t o, input logic w);
    slot_valid[idx]  = 1'b1;
    slot_handle[idx] = h;
    slot_order[idx]  = o;
    slot_wants[idx]  = w;
  endtask

  // free slot first; else replace the lower-order reference (slot 0 on ties)
  // unless that one is strictly newer than the incoming picture
  task automatic insert_reference(input handle_t h, input order_t o, input logic w);
    int victim;
    if (!slot_valid[0]) begin
      store_slot(0, h, o, w);
    end else if (!slot_valid[1]) begin
      store_slot(1, h, o, w);
    end else begin
      victim = (slot_order[0] > slot_order[1]) ? 1 : 0;
      if (!(slot_order[victim] > o)) store_slot(victim, h, o, w);
    end
  endtask

  task automatic apply_command(input item_in_t cmd, output item_out_t res);
    int     pick;
    int     prev_slot;
    int     next_slot;
    order_t best;
    res  = '0;
    best = '0;
    case (cmd.op)
      OP_ADD: begin
        if (!cmd.is_reference || (slot_valid[0] && slot_valid[1])) begin
          pend_valid  = 1'b1;
          pend_handle = handle_t'(cmd.pic_id);
          pend_order  = order_t'(cmd.order_count);
          pend_is_ref = cmd.is_reference;
          pend_wants  = cmd.needs_output;
        end else begin
          insert_reference(handle_t'(cmd.pic_id), order_t'(cmd.order_count),
                           cmd.needs_output);
        end
      end
      OP_BUMP: begin
        pick = PICK_NONE;
        for (int i = 0; i < NUM_REFS; i++) begin
          if (slot_valid[i] && slot_wants[i] && (pick == PICK_NONE || best > slot_order[i])) begin
            pick = i;
            best = slot_order[i];
          end
        end
        // pending only wins on a strictly lower order
        if (pend_valid && pend_wants && (pick == PICK_NONE || best > pend_order)) begin
          pick = PICK_PEND;
        end
        if (pick == PICK_PEND) begin
          res.out_valid = 1'b1;
          res.out_id    = 8'(pend_handle);
          pend_wants    = 1'b0;
        end else if (pick != PICK_NONE) begin
          res.out_valid    = 1'b1;
          res.out_id       = 8'(slot_handle[pick]);
          slot_wants[pick] = 1'b0;
        end
        if (pend_valid && pend_is_ref) begin
          insert_reference(pend_handle, pend_order, pend_wants);
          pend_valid = 1'b0;
        end else if (pick == PICK_PEND) begin
          pend_valid = 1'b0;
        end
      end
      OP_QUERY: begin
        prev_slot = PICK_NONE;
        next_slot = PICK_NONE;
        for (int i = 0; i < NUM_REFS; i++) begin
          if (slot_valid[i]) begin
            if (slot_order[i] > order_t'(cmd.order_count)) begin
              if (next_slot == PICK_NONE || slot_order[next_slot] > slot_order[i])
                next_slot = i;
            end else begin
              if (prev_slot == PICK_NONE || !(slot_order[prev_slot] > slot_order[i]))
                prev_slot = i;
            end
          end
        end
        if (prev_slot != PICK_NONE) begin
          res.prev_valid = 1'b1;
          res.prev_id    = 8'(slot_handle[prev_slot]);
        end
        if (next_slot != PICK_NONE) begin
          res.next_valid = 1'b1;
          res.next_id    = 8'(slot_handle[next_slot]);
        end
      end
      OP_CLEAR: begin
        empty_store();
      end
      default: ;
    endcase
    res.bump_pending = pend_valid;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_out_t exp_res;
    item_out_t new_res;
    if (!rst_ni) begin
      empty_store();
      expected_results.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no command waiting: %p", result_i);
          fail_count_o++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("out_valid",    32'(exp_res.out_valid),    32'(result_i.out_valid));
          check_field("out_id",       32'(exp_res.out_id),       32'(result_i.out_id));
          check_field("prev_valid",   32'(exp_res.prev_valid),   32'(result_i.prev_valid));
          check_field("prev_id",      32'(exp_res.prev_id),      32'(result_i.prev_id));
          check_field("next_valid",   32'(exp_res.next_valid),   32'(result_i.next_valid));
          check_field("next_id",      32'(exp_res.next_id),      32'(result_i.next_id));
          check_field("bump_pending", 32'(exp_res.bump_pending), 32'(result_i.bump_pending));
          checked_o++;
        end
      end
      if (start_i && !busy_i) begin
        apply_command(item_i, new_res);
        expected_results.push_back(new_res);
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the reference picture store with a directed run through the slot
// corner cases, then random command streams under three sender idle
// patterns; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import mrps_pkg::*;

  localparam int          ITEMS_PER_PHASE = 267;
  localparam int          STALL_LIMIT     = 2000;
  localparam logic [31:0] ORDER_MIN       = 32'h8000_0000;
  localparam logic [31:0] ORDER_MAX       = 32'h7FFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  item_in_t    item_in;
  logic        done_o;
  item_out_t   result_o;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned stall_cycles;
  int unsigned op_count[4];

  always #2 clk_i = ~clk_i;

  mpeg2_reference_picture_store DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_in),
    .done_o   (done_o),
    .result_o (result_o)
  );

  mrps_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .item_i        (item_in),
    .done_i        (done_o),
    .result_i      (result_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // cycles with neither a command nor a result taken
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[mpeg2_reference_picture_store] ERROR");
        $finish;
      end
    end
  end

  function automatic item_in_t make_cmd(op_e op, logic [7:0] id, logic [31:0] oc,
                                        logic is_ref, logic wants);
    item_in_t cmd;
    cmd.op           = op;
    cmd.pic_id       = id;
    cmd.order_count  = oc;
    cmd.is_reference = is_ref;
    cmd.needs_output = wants;
    return cmd;
  endfunction

  function automatic item_in_t random_cmd();
    item_in_t    cmd;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)      cmd.op = OP_ADD;
    else if (sel < 70) cmd.op = OP_BUMP;
    else if (sel < 95) cmd.op = OP_QUERY;
    else               cmd.op = OP_CLEAR;
    cmd.pic_id = 8'($urandom_range(0, 255));
    // narrow window for ties, some full-range and boundary values
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      cmd.order_count = $urandom_range(0, 15);
      cmd.order_count = cmd.order_count - 8;
    end else if (sel < 90) begin
      cmd.order_count = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       cmd.order_count = ORDER_MIN;
        1:       cmd.order_count = ORDER_MAX;
        2:       cmd.order_count = '0;
        default: cmd.order_count = '1;
      endcase
    end
    cmd.is_reference = ($urandom_range(0, 99) < 70);
    cmd.needs_output = ($urandom_range(0, 99) < 60);
    return cmd;
  endfunction

  task automatic send_cmd(input item_in_t cmd, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_in <= cmd;
    do @(posedge clk_i); while (busy_o);
    op_count[cmd.op]++;
  endtask

  // hold commands off until every predicted result has been seen
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    item_in_t    directed[$];
    int unsigned idle_pct[3];
    idle_pct = '{20, 69, 0};
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    item_in  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      make_cmd(OP_QUERY, 8'h00, 32'd0,     1'b0, 1'b0),  // empty store
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),  // nothing to output
      make_cmd(OP_ADD,   8'h00, ORDER_MIN, 1'b1, 1'b1),
      make_cmd(OP_ADD,   8'hFF, ORDER_MAX, 1'b1, 1'b1),
      make_cmd(OP_QUERY, 8'h00, 32'd0,     1'b0, 1'b0),
      make_cmd(OP_QUERY, 8'h00, ORDER_MAX, 1'b0, 1'b0),
      make_cmd(OP_ADD,   8'h5A, -32'sd5,   1'b0, 1'b1),  // non-ref to pending
      make_cmd(OP_ADD,   8'hA5, 32'd3,     1'b1, 1'b1),  // refs full: overwrites pending
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),  // pending ref replaces lower ref
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),
      make_cmd(OP_CLEAR, 8'hFF, ORDER_MAX, 1'b1, 1'b1),
      make_cmd(OP_ADD,   8'h01, 32'd7,     1'b1, 1'b1),
      make_cmd(OP_ADD,   8'h02, 32'd7,     1'b1, 1'b1),
      make_cmd(OP_QUERY, 8'h00, 32'd7,     1'b0, 1'b0),  // prev tie: later slot
      make_cmd(OP_QUERY, 8'h00, 32'd6,     1'b0, 1'b0),  // next tie: earlier slot
      make_cmd(OP_ADD,   8'h03, 32'd7,     1'b1, 1'b1),
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),  // equal orders, slot 0 wins
      make_cmd(OP_ADD,   8'h04, 32'd2,     1'b1, 1'b0),
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),  // older pending ref dropped
      make_cmd(OP_ADD,   8'h09, -32'sd1,   1'b0, 1'b0),
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),  // non-ref pending stays
      make_cmd(OP_ADD,   8'h0A, -32'sd100, 1'b0, 1'b1),
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),  // pending wins, no ref left to output
      make_cmd(OP_CLEAR, 8'h00, 32'd0,     1'b0, 1'b0),
      make_cmd(OP_ADD,   8'h11, 32'd0,     1'b1, 1'b0),
      make_cmd(OP_ADD,   8'h12, 32'd10,    1'b1, 1'b0),
      make_cmd(OP_ADD,   8'h13, 32'd4,     1'b1, 1'b1),
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0),  // output pending, then it enters refs
      make_cmd(OP_BUMP,  8'h00, 32'd0,     1'b0, 1'b0)
    };
    foreach (directed[i]) send_cmd(directed[i], 20);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_cmd(random_cmd(), idle_pct[phase]);
      drain();
    end
    repeat (4) @(posedge clk_i);

    $display("run covered %0d commands: %0d add, %0d bump, %0d query, %0d clear",
             op_count[OP_ADD] + op_count[OP_BUMP] + op_count[OP_QUERY] + op_count[OP_CLEAR],
             op_count[OP_ADD], op_count[OP_BUMP], op_count[OP_QUERY], op_count[OP_CLEAR]);
    $display("%0d results compared, sender idle at 20, 69 and 0 percent", checked);
    if (fail_count == 0) begin
      $display("[mpeg2_reference_picture_store] OK");
    end else begin
      $display("[mpeg2_reference_picture_store] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mrps_pkg.sv
sv/mrps_step.sv
sv/mpeg2_reference_picture_store.sv
verif/mrps_checker.sv
verif/tb.sv
